FILE: hw/rtl/cic_pkg.sv
// Shared types, codes and helpers for the cascaded interrupt controller pair.
package cic_pkg;

    // Item kinds on the input stream
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_ACK    = 2'd3
    } t_cmd;

    // Init sequence position: ready, or awaiting ICW2/ICW3/ICW4
    typedef enum logic [1:0] {
        INIT_READY = 2'd0,
        INIT_ICW2  = 2'd1,
        INIT_ICW3  = 2'd2,
        INIT_ICW4  = 2'd3
    } t_init_step;

    localparam int unsigned NUM_CHIPS   = 2;
    localparam int unsigned CHIP_MASTER = 0;
    localparam int unsigned CHIP_SLAVE  = 1;

    localparam logic [7:0] OCW2_NONSPEC_EOI = 8'h20;
    localparam logic [2:0] OCW2_SPEC_EOI_HI = 3'b011;   // bits 7:5 of a specific EOI
    localparam logic [7:0] CASCADE_MASK     = 8'h04;    // master IR2
    localparam logic [2:0] SLAVE_LEVEL      = 3'd2;
    localparam logic [2:0] SPURIOUS_LEVEL   = 3'd7;
    localparam logic [3:0] NO_BIT           = 4'd8;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_USER_W  = 4;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned OUT_USER_W = 1;

    // Index of the lowest set bit, NO_BIT when none
    function automatic logic [3:0] lowest_bit(input logic [7:0] v);
        logic [3:0] res;
        res = NO_BIT;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                res = 4'(i);
            end
        end
        return res;
    endfunction

    // Chip raises INT when its best unmasked request beats everything in service
    function automatic logic chip_int(input logic [7:0] irr, input logic [7:0] isr,
                                      input logic [7:0] imr);
        logic [7:0] pend;
        pend = irr & ~imr;
        return (pend != 8'h00) && (lowest_bit(pend) < lowest_bit(isr));
    endfunction

endpackage

FILE: hw/rtl/cascaded_interrupt_controller.sv
// Top level: master/slave 8259-style interrupt controller pair on a word stream.
//
//  Channel   Dir  tdata (low bit up)                          tuser (low bit up)
//  -------   ---  ------------------------------------------  ---------------------------
//  s (in)    in   write_data[7:0], request_lines[23:8]        cmd[1:0], chip[2], port_bit[3]
//  m (out)   out  read_data[7:0], interrupt_out[8],           vector_valid[0]
//                 vector[16:9], zero fill[23:17]
//
// Every input word gives exactly one output word. A word waits in the input register,
// where the whole register update (bus write, sample, acknowledge, cascade
// propagation) is worked out and committed along with the result register. Throughput
// is one word per cycle while the output is not stalled. The input register advances
// whenever the result register is empty or being taken, so a stalled output holds both
// stages and s_tready drops only when both are full. Synchronous active-low reset
// returns both chips to the power-up state (masks all set, edge mode, init sequence idle).
module cascaded_interrupt_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // write_data[7:0], request_lines[23:8]
    input  logic [cic_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // cmd[1:0], chip[2], port_bit[3]
    input  logic [cic_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // read_data[7:0], interrupt_out[8], vector[16:9], zero[23:17]
    output logic [cic_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // vector_valid[0]
    output logic [cic_pkg::OUT_USER_W-1:0]   o_m_tuser
);
    import cic_pkg::*;

    // ---------------- input register ----------------
    logic        r_in_valid;
    t_cmd        r_cmd;
    logic        r_chip;
    logic        r_port_bit;
    logic [7:0]  r_wdata;
    logic [15:0] r_lines;

    // ---------------- result register ----------------
    logic        r_out_valid;
    logic [7:0]  r_rdata;
    logic        r_int_out;
    logic [7:0]  r_vector;
    logic        r_vec_valid;

    // ---------------- per-chip state (0 master, 1 slave) ----------------
    logic [7:0]  r_irr    [NUM_CHIPS];
    logic [7:0]  r_isr    [NUM_CHIPS];
    logic [7:0]  r_imr    [NUM_CHIPS];
    logic [7:0]  r_prev   [NUM_CHIPS];
    logic [4:0]  r_base   [NUM_CHIPS];
    logic        r_level  [NUM_CHIPS];
    logic        r_aeoi   [NUM_CHIPS];
    logic        r_icw4   [NUM_CHIPS];
    logic        r_single [NUM_CHIPS];
    t_init_step  r_step   [NUM_CHIPS];
    logic        r_rsel   [NUM_CHIPS];

    logic [7:0]  n_irr    [NUM_CHIPS];
    logic [7:0]  n_isr    [NUM_CHIPS];
    logic [7:0]  n_imr    [NUM_CHIPS];
    logic [7:0]  n_prev   [NUM_CHIPS];
    logic [4:0]  n_base   [NUM_CHIPS];
    logic        n_level  [NUM_CHIPS];
    logic        n_aeoi   [NUM_CHIPS];
    logic        n_icw4   [NUM_CHIPS];
    logic        n_single [NUM_CHIPS];
    t_init_step  n_step   [NUM_CHIPS];
    logic        n_rsel   [NUM_CHIPS];

    logic [7:0]  n_rdata;
    logic        n_int_out;
    logic [7:0]  n_vector;
    logic        n_vec_valid;

    logic        advance;

    // helpers for the combinational step
    logic [7:0]  lines_m;
    logic [7:0]  lines_s;
    logic [7:0]  pend_m;
    logic [7:0]  pend_s;
    logic [3:0]  lvl_m;
    logic [3:0]  lvl_s;
    logic [2:0]  ack_m;
    logic [2:0]  ack_s;
    logic [7:0]  isr_low;
    logic        slave_int;

    // pipeline control: the input stage moves on whenever the result slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_cmd      <= t_cmd'(i_s_tuser[1:0]);
            r_chip     <= i_s_tuser[2];
            r_port_bit <= i_s_tuser[3];
            r_wdata    <= i_s_tdata[7:0];
            r_lines    <= i_s_tdata[23:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rdata     <= n_rdata;
            r_int_out   <= n_int_out;
            r_vector    <= n_vector;
            r_vec_valid <= n_vec_valid;
        end
    end

    // chip state commits together with the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHIPS; c++) begin
                r_irr[c]    <= 8'h00;
                r_isr[c]    <= 8'h00;
                r_imr[c]    <= 8'hFF;
                r_prev[c]   <= 8'h00;
                r_base[c]   <= 5'd0;
                r_level[c]  <= 1'b0;
                r_aeoi[c]   <= 1'b0;
                r_icw4[c]   <= 1'b0;
                r_single[c] <= 1'b0;
                r_step[c]   <= INIT_READY;
                r_rsel[c]   <= 1'b0;
            end
        end else if (advance) begin
            for (int c = 0; c < NUM_CHIPS; c++) begin
                r_irr[c]    <= n_irr[c];
                r_isr[c]    <= n_isr[c];
                r_imr[c]    <= n_imr[c];
                r_prev[c]   <= n_prev[c];
                r_base[c]   <= n_base[c];
                r_level[c]  <= n_level[c];
                r_aeoi[c]   <= n_aeoi[c];
                r_icw4[c]   <= n_icw4[c];
                r_single[c] <= n_single[c];
                r_step[c]   <= n_step[c];
                r_rsel[c]   <= n_rsel[c];
            end
        end
    end

    // one word: command effect, then cascade propagation, then master INT
    always_comb begin
        for (int c = 0; c < NUM_CHIPS; c++) begin
            n_irr[c]    = r_irr[c];
            n_isr[c]    = r_isr[c];
            n_imr[c]    = r_imr[c];
            n_prev[c]   = r_prev[c];
            n_base[c]   = r_base[c];
            n_level[c]  = r_level[c];
            n_aeoi[c]   = r_aeoi[c];
            n_icw4[c]   = r_icw4[c];
            n_single[c] = r_single[c];
            n_step[c]   = r_step[c];
            n_rsel[c]   = r_rsel[c];
        end
        n_rdata     = 8'h00;
        n_vector    = 8'h00;
        n_vec_valid = 1'b0;

        lines_m = r_lines[7:0];
        lines_s = r_lines[15:8];
        pend_m  = r_irr[CHIP_MASTER] & ~r_imr[CHIP_MASTER];
        pend_s  = r_irr[CHIP_SLAVE] & ~r_imr[CHIP_SLAVE];
        lvl_m   = lowest_bit(pend_m);
        lvl_s   = lowest_bit(pend_s);
        isr_low = r_isr[r_chip] & (~r_isr[r_chip] + 8'd1);   // lowest in-service bit
        ack_m   = SPURIOUS_LEVEL;
        ack_s   = SPURIOUS_LEVEL;

        unique case (r_cmd)
            CMD_WRITE: begin
                if (!r_port_bit) begin
                    if (r_wdata[4]) begin
                        // ICW1: restart init; edge history kept
                        n_irr[r_chip]    = 8'h00;
                        n_isr[r_chip]    = 8'h00;
                        n_imr[r_chip]    = 8'h00;
                        n_aeoi[r_chip]   = 1'b0;
                        n_rsel[r_chip]   = 1'b0;
                        n_level[r_chip]  = r_wdata[3];
                        n_single[r_chip] = r_wdata[1];
                        n_icw4[r_chip]   = r_wdata[0];
                        n_step[r_chip]   = INIT_ICW2;
                    end else if (r_wdata[3]) begin
                        // OCW3: only the register read select is honoured
                        if (r_wdata[1]) begin
                            n_rsel[r_chip] = r_wdata[0];
                        end
                    end else if (r_wdata == OCW2_NONSPEC_EOI) begin
                        n_isr[r_chip] = r_isr[r_chip] & ~isr_low;
                    end else if (r_wdata[7:5] == OCW2_SPEC_EOI_HI) begin
                        n_isr[r_chip] = r_isr[r_chip] & ~(8'h01 << r_wdata[2:0]);
                    end
                end else begin
                    unique case (r_step[r_chip])
                        INIT_ICW2: begin
                            n_base[r_chip] = r_wdata[7:3];
                            if (r_single[r_chip]) begin
                                n_step[r_chip] = r_icw4[r_chip] ? INIT_ICW4 : INIT_READY;
                            end else begin
                                n_step[r_chip] = INIT_ICW3;
                            end
                        end
                        INIT_ICW3: begin
                            // wiring is fixed, ICW3 contents unused
                            n_step[r_chip] = r_icw4[r_chip] ? INIT_ICW4 : INIT_READY;
                        end
                        INIT_ICW4: begin
                            n_aeoi[r_chip] = r_wdata[1];
                            n_step[r_chip] = INIT_READY;
                        end
                        INIT_READY: begin
                            n_imr[r_chip] = r_wdata;
                        end
                    endcase
                end
            end
            CMD_READ: begin
                if (r_port_bit) begin
                    n_rdata = r_imr[r_chip];
                end else begin
                    n_rdata = r_rsel[r_chip] ? r_isr[r_chip] : r_irr[r_chip];
                end
            end
            CMD_SAMPLE: begin
                // slave takes all eight lines, master all but the cascade input
                if (r_level[CHIP_SLAVE]) begin
                    n_irr[CHIP_SLAVE] = lines_s;
                end else begin
                    n_irr[CHIP_SLAVE] = r_irr[CHIP_SLAVE] | (lines_s & ~r_prev[CHIP_SLAVE]);
                end
                n_prev[CHIP_SLAVE] = lines_s;
                if (r_level[CHIP_MASTER]) begin
                    n_irr[CHIP_MASTER] = (r_irr[CHIP_MASTER] & CASCADE_MASK)
                                       | (lines_m & ~CASCADE_MASK);
                end else begin
                    n_irr[CHIP_MASTER] = r_irr[CHIP_MASTER]
                                       | (lines_m & ~r_prev[CHIP_MASTER] & ~CASCADE_MASK);
                end
                n_prev[CHIP_MASTER] = (r_prev[CHIP_MASTER] & CASCADE_MASK)
                                    | (lines_m & ~CASCADE_MASK);
            end
            CMD_ACK: begin
                n_vec_valid = 1'b1;
                if (chip_int(r_irr[CHIP_MASTER], r_isr[CHIP_MASTER], r_imr[CHIP_MASTER]))
                begin
                    ack_m = lvl_m[2:0];
                    n_irr[CHIP_MASTER] = r_irr[CHIP_MASTER] & ~(8'h01 << ack_m);
                    if (!r_aeoi[CHIP_MASTER]) begin
                        n_isr[CHIP_MASTER] = r_isr[CHIP_MASTER] | (8'h01 << ack_m);
                    end
                end
                if (ack_m == SLAVE_LEVEL && !r_single[CHIP_MASTER]) begin
                    // the vector then comes from the slave; spurious there also gives level 7
                    if (chip_int(r_irr[CHIP_SLAVE], r_isr[CHIP_SLAVE], r_imr[CHIP_SLAVE]))
                    begin
                        ack_s = lvl_s[2:0];
                        n_irr[CHIP_SLAVE] = r_irr[CHIP_SLAVE] & ~(8'h01 << ack_s);
                        if (!r_aeoi[CHIP_SLAVE]) begin
                            n_isr[CHIP_SLAVE] = r_isr[CHIP_SLAVE] | (8'h01 << ack_s);
                        end
                    end
                    n_vector = {r_base[CHIP_SLAVE], ack_s};
                end else begin
                    n_vector = {r_base[CHIP_MASTER], ack_m};
                end
            end
        endcase

        // slave INT feeds master IR2 through the master's own trigger logic
        slave_int = chip_int(n_irr[CHIP_SLAVE], n_isr[CHIP_SLAVE], n_imr[CHIP_SLAVE]);
        if (n_level[CHIP_MASTER]) begin
            n_irr[CHIP_MASTER][SLAVE_LEVEL] = slave_int;
        end else begin
            n_irr[CHIP_MASTER][SLAVE_LEVEL] = n_irr[CHIP_MASTER][SLAVE_LEVEL]
                                            | (slave_int & ~n_prev[CHIP_MASTER][SLAVE_LEVEL]);
        end
        n_prev[CHIP_MASTER][SLAVE_LEVEL] = slave_int;

        n_int_out = chip_int(n_irr[CHIP_MASTER], n_isr[CHIP_MASTER], n_imr[CHIP_MASTER]);
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_vector, r_int_out, r_rdata};
    assign o_m_tuser  = r_vec_valid;

endmodule

FILE: tb/tb_cascaded_interrupt_controller.sv
// Self-checking testbench for the cascaded master/slave interrupt controller pair.
`timescale 1ns / 1ps

module tb_cascaded_interrupt_controller;
    import cic_pkg::*;

    // Bit positions inside the command bytes
    localparam int ICW1_IC4_BIT   = 0;
    localparam int ICW1_SNGL_BIT  = 1;
    localparam int ICW1_LTIM_BIT  = 3;
    localparam int ICW1_INIT_BIT  = 4;
    localparam int ICW4_AEOI_BIT  = 1;
    localparam int OCW3_RIS_BIT   = 0;
    localparam int OCW3_RR_BIT    = 1;
    localparam int OCW3_FLAG_BIT  = 3;

    localparam bit SEL_MASTER = 1'(CHIP_MASTER);
    localparam bit SEL_SLAVE  = 1'(CHIP_SLAVE);
    localparam bit PORT_CMD   = 1'b0;
    localparam bit PORT_DATA  = 1'b1;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 4;     // two-stage pipe plus margin
    localparam int RANDOM_TARGET  = 1650;  // words sent before back-pressure and tail

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_DATA_W-1:0]    i_s_tdata;   // write_data[7:0], request_lines[23:8]
    logic [IN_USER_W-1:0]    i_s_tuser;   // cmd[1:0], chip[2], port_bit[3]
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_DATA_W-1:0]   o_m_tdata;   // read_data[7:0], interrupt_out[8], vector[16:9]
    logic [OUT_USER_W-1:0]   o_m_tuser;   // vector_valid[0]

    cascaded_interrupt_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Field order matches the concatenation taken from the output ports
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] vector;
        logic       vector_valid;
    } t_reply;

    t_reply awaited_replies[$];

    // Shadow copy of both chips (index 0 master, 1 slave)
    logic [7:0] irr        [NUM_CHIPS];
    logic [7:0] isr        [NUM_CHIPS];
    logic [7:0] imr        [NUM_CHIPS];
    logic [7:0] seen_lines [NUM_CHIPS];   // edge-detect history
    logic [4:0] vbase      [NUM_CHIPS];
    logic       level_trig [NUM_CHIPS];
    logic       aeoi       [NUM_CHIPS];
    logic       need_icw4  [NUM_CHIPS];
    logic       single_chip[NUM_CHIPS];
    logic       show_isr   [NUM_CHIPS];
    t_init_step init_pos   [NUM_CHIPS];

    int  mismatches   = 0;
    int  words_sent   = 0;
    int  cycle_count  = 0;
    int  hold_request = 0;
    bit  src_idle_on  = 1'b0;
    bit  sink_idle_on = 1'b0;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_cascaded_interrupt_controller failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [3:0] first_set(input logic [7:0] v);
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                return 4'(i);
            end
        end
        return NO_BIT;
    endfunction

    // INT out of one chip: best unmasked request must outrank everything in service
    function automatic bit raises_int(input int c);
        logic [7:0] pend;
        pend = irr[c] & ~imr[c];
        return (pend != 8'h00) && (first_set(pend) < first_set(isr[c]));
    endfunction

    // Edge mode latches rising levels only; level mode makes IRR track the lines
    function automatic void latch_lines(input int c, input logic [7:0] lines,
                                        input logic [7:0] sel);
        logic [7:0] rise;
        rise = lines & ~seen_lines[c] & sel;
        if (level_trig[c]) begin
            irr[c] = (irr[c] & ~sel) | (lines & sel);
        end else begin
            irr[c] = irr[c] | rise;
        end
        seen_lines[c] = (seen_lines[c] & ~sel) | (lines & sel);
    endfunction

    // Acknowledge cycle on one chip; spurious gives level 7 with nothing put in service
    function automatic logic [2:0] take_level(input int c);
        logic [3:0] lvl;
        if (!raises_int(c)) begin
            return SPURIOUS_LEVEL;
        end
        lvl = first_set(irr[c] & ~imr[c]);
        irr[c][lvl[2:0]] = 1'b0;
        if (!aeoi[c]) begin
            isr[c][lvl[2:0]] = 1'b1;
        end
        return lvl[2:0];
    endfunction

    function automatic void apply_write(input int c, input bit a0, input logic [7:0] d);
        logic [3:0] top;
        if (a0 == PORT_CMD) begin
            if (d[ICW1_INIT_BIT]) begin
                // ICW1: restart init; edge history deliberately kept
                irr[c]         = 8'h00;
                isr[c]         = 8'h00;
                imr[c]         = 8'h00;
                aeoi[c]        = 1'b0;
                show_isr[c]    = 1'b0;
                level_trig[c]  = d[ICW1_LTIM_BIT];
                single_chip[c] = d[ICW1_SNGL_BIT];
                need_icw4[c]   = d[ICW1_IC4_BIT];
                init_pos[c]    = INIT_ICW2;
            end else if (d[OCW3_FLAG_BIT]) begin
                if (d[OCW3_RR_BIT]) begin
                    show_isr[c] = d[OCW3_RIS_BIT];
                end
            end else if (d == OCW2_NONSPEC_EOI) begin
                top = first_set(isr[c]);
                if (top != NO_BIT) begin
                    isr[c][top[2:0]] = 1'b0;
                end
            end else if (d[7:5] == OCW2_SPEC_EOI_HI) begin
                isr[c][d[2:0]] = 1'b0;
            end
        end else begin
            case (init_pos[c])
                INIT_ICW2: begin
                    vbase[c] = d[7:3];
                    if (!single_chip[c]) begin
                        init_pos[c] = INIT_ICW3;
                    end else if (need_icw4[c]) begin
                        init_pos[c] = INIT_ICW4;
                    end else begin
                        init_pos[c] = INIT_READY;
                    end
                end
                INIT_ICW3: begin
                    // wiring is fixed, so the byte itself is dropped
                    init_pos[c] = need_icw4[c] ? INIT_ICW4 : INIT_READY;
                end
                INIT_ICW4: begin
                    aeoi[c]     = d[ICW4_AEOI_BIT];
                    init_pos[c] = INIT_READY;
                end
                default: begin
                    imr[c] = d;
                end
            endcase
        end
    endfunction

    // One accepted word in, one expected reply queued
    function automatic void pic_apply_word(input t_cmd cmd, input bit c, input bit a0,
                                           input logic [7:0] d, input logic [15:0] lines);
        t_reply     r;
        logic [2:0] lvl;
        logic [2:0] sl;
        r = '0;
        case (cmd)
            CMD_WRITE: begin
                apply_write(c, a0, d);
            end
            CMD_READ: begin
                if (a0 == PORT_DATA) begin
                    r.read_data = imr[c];
                end else begin
                    r.read_data = show_isr[c] ? isr[c] : irr[c];
                end
            end
            CMD_SAMPLE: begin
                latch_lines(CHIP_SLAVE, lines[15:8], 8'hFF);
                latch_lines(CHIP_MASTER, lines[7:0], ~CASCADE_MASK);
            end
            default: begin
                r.vector_valid = 1'b1;
                lvl = take_level(CHIP_MASTER);
                if (lvl == SLAVE_LEVEL && !single_chip[CHIP_MASTER]) begin
                    sl = take_level(CHIP_SLAVE);
                    r.vector = {vbase[CHIP_SLAVE], sl};
                end else begin
                    r.vector = {vbase[CHIP_MASTER], lvl};
                end
            end
        endcase
        // slave INT feeds master IR2 through the master's own trigger logic
        latch_lines(CHIP_MASTER, raises_int(CHIP_SLAVE) ? CASCADE_MASK : 8'h00, CASCADE_MASK);
        r.irq = raises_int(CHIP_MASTER);
        awaited_replies.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Reply checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_reply(input t_reply got);
        t_reply want;
        if (awaited_replies.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected reply word, expected none, actual %h", $time, got);
            return;
        end
        want = awaited_replies.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("interrupt_out", 8'(want.irq), 8'(got.irq));
        check_field("vector", want.vector, got.vector);
        check_field("vector_valid", 8'(want.vector_valid), 8'(got.vector_valid));
    endfunction

    // Values sampled at the edge are the pre-edge ones, i.e. the handshake itself
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            check_reply({o_m_tdata[7:0], o_m_tdata[8], o_m_tdata[16:9], o_m_tuser[0]});
        end
    end

    // ------------------------------------------------------------------
    // Reply sink: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Word source
    // ------------------------------------------------------------------
    // Returns at the edge where the word is taken; tvalid is left high so
    // back-to-back words need no dip.
    task automatic send_word(input t_cmd cmd, input bit c, input bit a0,
                             input logic [7:0] wd, input logic [15:0] lines);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {lines, wd};
        i_s_tuser  <= {a0, c, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        pic_apply_word(cmd, c, a0, wd, lines);
        words_sent++;
    endtask

    // One random operation, weighted towards traffic that moves interrupts along
    task automatic send_random_op();
        int          pick;
        logic [7:0]  d;
        logic [15:0] lines;
        bit          c;
        bit          a0;
        pick  = $urandom_range(0, 99);
        d     = 8'($urandom);
        lines = 16'($urandom);
        c     = 1'($urandom);
        a0    = 1'($urandom);
        if (pick < 30) begin
            // sparse or quiet samples give edges for the edge-triggered inputs
            case ($urandom_range(0, 3))
                0: lines = lines & 16'($urandom) & 16'($urandom);
                1: lines = 16'h0000;
                default: ;
            endcase
            send_word(CMD_SAMPLE, c, a0, d, lines);
        end else if (pick < 52) begin
            send_word(CMD_ACK, c, a0, d, lines);
        end else if (pick < 66) begin
            send_word(CMD_READ, c, a0, d, lines);
        end else if (pick < 80) begin
            if ($urandom_range(0, 1) == 0) begin
                d = OCW2_NONSPEC_EOI;
            end else begin
                d = {OCW2_SPEC_EOI_HI, 2'b00, d[2:0]};
            end
            send_word(CMD_WRITE, c, PORT_CMD, d, lines);
        end else if (pick < 86) begin
            d[ICW1_INIT_BIT] = 1'b0;
            d[OCW3_FLAG_BIT] = 1'b1;
            send_word(CMD_WRITE, c, PORT_CMD, d, lines);
        end else if (pick < 93) begin
            send_word(CMD_WRITE, c, PORT_DATA, d & 8'($urandom), lines);
        end else if (pick < 98) begin
            send_word(CMD_WRITE, c, a0, d, lines);
        end else begin
            // stray ICW1: the next data-port writes become ICWs
            d[ICW1_INIT_BIT] = 1'b1;
            send_word(CMD_WRITE, c, PORT_CMD, d, lines);
        end
    endtask

    // Well-formed init with random content; now and then traffic lands mid-sequence
    task automatic send_init(input bit c);
        logic [7:0] icw1;
        icw1 = 8'($urandom);
        icw1[ICW1_INIT_BIT] = 1'b1;
        icw1[ICW1_SNGL_BIT] = ($urandom_range(0, 5) == 0);
        send_word(CMD_WRITE, c, PORT_CMD, icw1, 16'($urandom));
        if ($urandom_range(0, 7) == 0) send_random_op();
        send_word(CMD_WRITE, c, PORT_DATA, 8'($urandom), 16'($urandom));
        if (!icw1[ICW1_SNGL_BIT]) begin
            if ($urandom_range(0, 7) == 0) send_random_op();
            send_word(CMD_WRITE, c, PORT_DATA, 8'($urandom), 16'($urandom));
        end
        if (icw1[ICW1_IC4_BIT]) begin
            send_word(CMD_WRITE, c, PORT_DATA, 8'($urandom), 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Power-up: masks all set, nothing pending, acknowledge is spurious
    task automatic test_power_up();
        send_word(CMD_READ, SEL_MASTER, PORT_DATA, 8'h00, 16'h0000);
        send_word(CMD_READ, SEL_SLAVE, PORT_CMD, 8'h00, 16'h0000);
        send_word(CMD_SAMPLE, SEL_MASTER, PORT_CMD, 8'hFF, 16'hFFFF);
        send_word(CMD_READ, SEL_MASTER, PORT_CMD, 8'h00, 16'h0000);
        send_word(CMD_ACK, SEL_MASTER, PORT_CMD, 8'h00, 16'h0000);
    endtask

    // Full ICW1-ICW4 on both chips; top vector base on the master, slave level-triggered
    task automatic test_init_sequences();
        send_word(CMD_WRITE, SEL_MASTER, PORT_CMD, 8'h11, 16'hFFFF);
        send_word(CMD_WRITE, SEL_MASTER, PORT_DATA, 8'hF8, 16'h0000);
        send_word(CMD_WRITE, SEL_MASTER, PORT_DATA, 8'h04, 16'h0000);
        send_word(CMD_WRITE, SEL_MASTER, PORT_DATA, 8'h03, 16'h0000);
        send_word(CMD_WRITE, SEL_SLAVE, PORT_CMD, 8'h19, 16'h0000);
        send_word(CMD_WRITE, SEL_SLAVE, PORT_DATA, 8'h00, 16'h0000);
        send_word(CMD_WRITE, SEL_SLAVE, PORT_DATA, 8'h02, 16'h0000);
        send_word(CMD_WRITE, SEL_SLAVE, PORT_DATA, 8'h01, 16'h0000);
    endtask

    // Kept edge history needs a fresh rise; nesting through the cascade; ISR readback; EOIs
    task automatic test_nested_service();
        send_word(CMD_SAMPLE, SEL_SLAVE, PORT_DATA, 8'h00, 16'h0000);
        send_word(CMD_SAMPLE, SEL_MASTER, PORT_CMD, 8'h00, 16'h8081);
        send_word(CMD_ACK, SEL_MASTER, PORT_CMD, 8'h00, 16'h0000);
        send_word(CMD_ACK, SEL_SLAVE, PORT_DATA, 8'h00, 16'h0000);
        send_word(CMD_WRITE, SEL_SLAVE, PORT_CMD, 8'h0B, 16'h0000);
        send_word(CMD_READ, SEL_SLAVE, PORT_CMD, 8'h00, 16'h0000);
        send_word(CMD_WRITE, SEL_SLAVE, PORT_CMD, {OCW2_SPEC_EOI_HI, 5'h07}, 16'h0000);
        send_word(CMD_WRITE, SEL_SLAVE, PORT_CMD, OCW2_NONSPEC_EOI, 16'h0000);
        send_word(CMD_ACK, SEL_MASTER, PORT_CMD, 8'h00, 16'h0000);
    endtask

    // Master in single mode: IR2 answers with the master's own base plus 2
    task automatic test_single_master();
        send_word(CMD_WRITE, SEL_MASTER, PORT_CMD, 8'h1A, 16'h0000);
        send_word(CMD_WRITE, SEL_MASTER, PORT_DATA, 8'h40, 16'h0000);
        send_word(CMD_SAMPLE, SEL_MASTER, PORT_CMD, 8'h00, 16'h0104);
        send_word(CMD_ACK, SEL_MASTER, PORT_CMD, 8'h00, 16'h0000);
    endtask

    // Bulk of the run: re-initialise now and then, traffic in between
    task automatic test_random_traffic(input int target);
        while (words_sent < target) begin
            if ($urandom_range(0, 4) == 0) send_init(SEL_MASTER);
            if ($urandom_range(0, 4) == 0) send_init(SEL_SLAVE);
            repeat ($urandom_range(10, 60)) send_random_op();
        end
    endtask

    // Sink holds off long enough for both pipe stages to fill and tready to drop
    task automatic test_output_backpressure();
        src_idle_on  = 1'b0;
        hold_request = 120;
        repeat (40) send_random_op();
        src_idle_on  = 1'b1;
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate_tail();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_init(SEL_MASTER);
        send_init(SEL_SLAVE);
        repeat (200) send_random_op();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        for (int c = 0; c < NUM_CHIPS; c++) begin
            irr[c]         = 8'h00;
            isr[c]         = 8'h00;
            imr[c]         = 8'hFF;
            seen_lines[c]  = 8'h00;
            vbase[c]       = 5'h00;
            level_trig[c]  = 1'b0;
            aeoi[c]        = 1'b0;
            need_icw4[c]   = 1'b0;
            single_chip[c] = 1'b0;
            show_isr[c]    = 1'b0;
            init_pos[c]    = INIT_READY;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_power_up();
        test_init_sequences();
        test_nested_service();
        test_single_master();
        test_random_traffic(RANDOM_TARGET);
        test_output_backpressure();
        test_full_rate_tail();

        i_s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_cascaded_interrupt_controller passed");
        end else begin
            $display("tb_cascaded_interrupt_controller failed");
        end
        $finish;
    end

endmodule
